// ===== rtl/core/wsts_pkg.sv =====
package wsts_pkg;

  // fixed field widths of the channels
  localparam int WIDX_BITS       = 3;
  localparam int TASK_FIELD_BITS = 16;
  localparam int CFG_BITS        = 4;
  localparam int PEND_FIELD_BITS = 8;

  // active worker count after reset
  localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 4'd8;

  // largest pending total the result field can carry
  localparam int PEND_FIELD_MAX = 255;

  // item kinds on the mode field
  localparam logic MODE_SUBMIT  = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // what an accepted item does to the deques
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2,
    OP_STEAL = 2'd3
  } op_t;

endpackage

// ===== rtl/core/wsts_if.sv =====
interface wsts_req_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    mode;
  logic [wsts_pkg::WIDX_BITS-1:0]          worker_index;
  logic [wsts_pkg::TASK_FIELD_BITS-1:0]    task_in;

  modport source (output valid, mode, worker_index, task_in, input ready);
  modport sink   (input valid, mode, worker_index, task_in, output ready);
endinterface

interface wsts_res_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    granted;
  logic [wsts_pkg::TASK_FIELD_BITS-1:0]    task_out;
  logic [wsts_pkg::WIDX_BITS-1:0]          source_worker;
  logic                                    stolen;
  logic                                    dropped;
  logic [wsts_pkg::PEND_FIELD_BITS-1:0]    pending_total;

  modport source (output valid, granted, task_out, source_worker, stolen, dropped,
                  pending_total, input ready);
  modport sink   (input valid, granted, task_out, source_worker, stolen, dropped,
                  pending_total, output ready);
endinterface

interface wsts_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [wsts_pkg::CFG_BITS-1:0]           active_workers;

  modport source (output valid, active_workers, input ready);
  modport sink   (input valid, active_workers, output ready);
endinterface

// ===== rtl/core/work_stealing_task_scheduler.sv =====
// channel    | role  | payload
// -----------+-------+-------------------------------------------------------------
// task_req   | sink  | mode, worker_index, task_in
// task_res   | source| granted, task_out, source_worker, stolen, dropped, pending_total
// cfg        | sink  | active_workers (always ready)
//
// a transfer on task_req issues the read of the per-worker head/count memory;
// the update stage then writes that memory and touches the task store (write for
// a push, read for a pop or steal); task_req.ready is low while it holds an item.
// the result is registered on task_res and holds there until taken; one further
// item can sit in the update stage behind it while the result side stalls.
// reset is synchronous; no clearing pass, per-worker written bits mark the
// head/count entries that still read as zero.
module work_stealing_task_scheduler #(
  parameter int NUM_WORKERS = 8,
  parameter int DEQUE_DEPTH = 16,
  parameter int TASK_BITS   = 16
) (
  input  logic           clk,
  input  logic           rst,
  wsts_req_if.sink       task_req,
  wsts_res_if.source     task_res,
  wsts_cfg_if.sink       cfg
);

  localparam int WidBits   = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int HeadBits  = $clog2(DEQUE_DEPTH);
  localparam int CountBits = $clog2(DEQUE_DEPTH + 1);
  localparam int MetaBits  = HeadBits + CountBits;
  localparam int AddrBits  = $clog2(NUM_WORKERS * DEQUE_DEPTH);
  localparam int PendBits  = $clog2(NUM_WORKERS * DEQUE_DEPTH + 1);
  // identifiers wider than the channel field are cut to it anyway
  localparam int StoreBits = (TASK_BITS < wsts_pkg::TASK_FIELD_BITS) ?
                             TASK_BITS : wsts_pkg::TASK_FIELD_BITS;
  // the live count can never exceed what the 4-bit register holds
  localparam int NumCap    = (NUM_WORKERS < 15) ? NUM_WORKERS : 15;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic [wsts_pkg::CFG_BITS-1:0] active_workers;
  logic [wsts_pkg::CFG_BITS-1:0] live_n;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= wsts_pkg::ACTIVE_RESET;
    end else if (cfg.valid) begin
      active_workers <= cfg.active_workers;
    end
  end

  // zero acts as one, anything past the worker count acts as the worker count
  always_comb begin
    if (active_workers == '0) begin
      live_n = wsts_pkg::CFG_BITS'(1);
    end else if (int'(active_workers) > NumCap) begin
      live_n = wsts_pkg::CFG_BITS'(NumCap);
    end else begin
      live_n = active_workers;
    end
  end

  // ---------------------------------------------------------------------------
  // per-worker flags in flops: written, non-empty, full
  // ---------------------------------------------------------------------------
  logic [NUM_WORKERS-1:0] written;
  logic [NUM_WORKERS-1:0] nonempty;
  logic [NUM_WORKERS-1:0] full;

  // ---------------------------------------------------------------------------
  // accept stage: classify the item and pick the deque it works on
  // ---------------------------------------------------------------------------
  logic                   s1_valid;
  logic                   s2_valid;
  logic [WidBits-1:0]     s1_target;
  logic                   accept;
  logic [WidBits-1:0]     wi;
  logic                   own_ok;
  logic [NUM_WORKERS-1:0] steal_mask;
  logic                   hi_hit;
  logic [WidBits-1:0]     hi_id;
  logic                   any_hit;
  logic [WidBits-1:0]     any_id;
  wsts_pkg::op_t          pick_op;
  logic [WidBits-1:0]     pick_target;
  logic                   pick_dropped;

  // the update stage must finish before the flags are trusted again
  assign task_req.ready = !s1_valid;
  assign accept         = task_req.valid && task_req.ready;

  assign wi     = WidBits'(task_req.worker_index);
  assign own_ok = {1'b0, task_req.worker_index} < live_n;

  // rotating pick: first non-empty live deque above the requester, else the lowest
  always_comb begin
    hi_hit  = 1'b0;
    hi_id   = '0;
    any_hit = 1'b0;
    any_id  = '0;
    for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
      steal_mask[i] = nonempty[i] && (i < int'(live_n));
      if (steal_mask[i]) begin
        any_hit = 1'b1;
        any_id  = WidBits'(i);
        if (i > int'(wi)) begin
          hi_hit = 1'b1;
          hi_id  = WidBits'(i);
        end
      end
    end
  end

  always_comb begin
    pick_op      = wsts_pkg::OP_NONE;
    pick_target  = wi;
    pick_dropped = 1'b0;
    priority if (task_req.mode == wsts_pkg::MODE_SUBMIT) begin
      // bad index or full deque refuses the task
      if (own_ok && !full[wi]) begin
        pick_op = wsts_pkg::OP_PUSH;
      end else begin
        pick_dropped = 1'b1;
      end
    end else if (!own_ok) begin
      pick_op = wsts_pkg::OP_NONE;
    end else if (nonempty[wi]) begin
      pick_op = wsts_pkg::OP_POP;
    end else if (any_hit) begin
      pick_op     = wsts_pkg::OP_STEAL;
      pick_target = hi_hit ? hi_id : any_id;
    end else begin
      pick_op = wsts_pkg::OP_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // head/count memory, one entry per worker
  // ---------------------------------------------------------------------------
  logic [MetaBits-1:0] meta_mem [NUM_WORKERS];
  logic [MetaBits-1:0] meta_rd;
  logic                meta_we;
  logic [MetaBits-1:0] meta_wdata;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[s1_target] <= meta_wdata;
    end
    if (accept) begin
      meta_rd <= meta_mem[pick_target];
    end
  end

  // ---------------------------------------------------------------------------
  // update stage
  // ---------------------------------------------------------------------------
  wsts_pkg::op_t                         s1_op;
  logic                                  s1_dropped;
  logic [wsts_pkg::TASK_FIELD_BITS-1:0]  s1_task;

  logic                   s1_go;
  logic [HeadBits-1:0]    head;
  logic [CountBits-1:0]   cnt;
  logic [HeadBits:0]      off;
  logic [HeadBits:0]      slot_sum;
  logic [HeadBits-1:0]    slot;
  logic [HeadBits-1:0]    head_next;
  logic [CountBits-1:0]   cnt_next;
  logic                   is_take;
  logic [PendBits-1:0]    pending;
  logic [PendBits-1:0]    pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= pick_op;
      s1_target  <= pick_target;
      s1_dropped <= pick_dropped;
      s1_task    <= task_req.task_in;
    end
  end

  // stage moves on when the result slot is free or being emptied
  assign s1_go   = s1_valid && (!s2_valid || task_res.ready);
  assign is_take = (s1_op == wsts_pkg::OP_POP) || (s1_op == wsts_pkg::OP_STEAL);

  // never-written entries read as the reset value
  assign head = written[s1_target] ? meta_rd[HeadBits-1:0] : '0;
  assign cnt  = written[s1_target] ? meta_rd[MetaBits-1:HeadBits] : '0;

  always_comb begin
    unique case (s1_op)
      wsts_pkg::OP_PUSH: off = (HeadBits + 1)'(cnt);
      wsts_pkg::OP_POP:  off = (HeadBits + 1)'(cnt - CountBits'(1));
      default:           off = '0;
    endcase
    // back slot for push/pop, front slot for steal; sum stays below twice the depth
    slot_sum = {1'b0, head} + off;
    if (slot_sum >= (HeadBits + 1)'(DEQUE_DEPTH)) begin
      slot = HeadBits'(slot_sum - (HeadBits + 1)'(DEQUE_DEPTH));
    end else begin
      slot = HeadBits'(slot_sum);
    end
    if (s1_op == wsts_pkg::OP_STEAL) begin
      head_next = (head == HeadBits'(DEQUE_DEPTH - 1)) ? '0 : head + HeadBits'(1);
    end else begin
      head_next = head;
    end
    if (s1_op == wsts_pkg::OP_PUSH) begin
      cnt_next     = cnt + CountBits'(1);
      pending_next = pending + PendBits'(1);
    end else if (is_take) begin
      cnt_next     = cnt - CountBits'(1);
      pending_next = pending - PendBits'(1);
    end else begin
      cnt_next     = cnt;
      pending_next = pending;
    end
  end

  assign meta_we    = s1_go && (s1_op != wsts_pkg::OP_NONE);
  assign meta_wdata = {cnt_next, head_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      nonempty <= '0;
      full     <= '0;
      pending  <= '0;
    end else if (meta_we) begin
      written[s1_target]  <= 1'b1;
      nonempty[s1_target] <= (cnt_next != '0);
      full[s1_target]     <= (cnt_next == CountBits'(DEQUE_DEPTH));
      pending             <= pending_next;
    end
  end

  // ---------------------------------------------------------------------------
  // task store, DEQUE_DEPTH slots per worker
  // ---------------------------------------------------------------------------
  logic [StoreBits-1:0] store [NUM_WORKERS * DEQUE_DEPTH];
  logic [StoreBits-1:0] store_rd;
  logic [AddrBits-1:0]  store_addr;

  assign store_addr = AddrBits'(s1_target) * AddrBits'(DEQUE_DEPTH) + AddrBits'(slot);

  always_ff @(posedge clk) begin
    if (s1_go && (s1_op == wsts_pkg::OP_PUSH)) begin
      store[store_addr] <= StoreBits'(s1_task);
    end
    if (s1_go && is_take) begin
      store_rd <= store[store_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // result stage; store read data lands here alongside the flags
  // ---------------------------------------------------------------------------
  logic                                  s2_granted;
  logic [wsts_pkg::WIDX_BITS-1:0]        s2_source;
  logic                                  s2_stolen;
  logic                                  s2_dropped;
  logic [wsts_pkg::PEND_FIELD_BITS-1:0]  s2_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go) begin
      s2_valid <= 1'b1;
    end else if (task_res.ready) begin
      s2_valid <= 1'b0;
    end
  end

  // pending total is captured here so later items cannot disturb a waiting result
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_granted <= is_take;
      s2_source  <= is_take ? wsts_pkg::WIDX_BITS'(s1_target) : '0;
      s2_stolen  <= (s1_op == wsts_pkg::OP_STEAL);
      s2_dropped <= s1_dropped;
      if (int'(pending_next) > wsts_pkg::PEND_FIELD_MAX) begin
        s2_pending <= wsts_pkg::PEND_FIELD_BITS'(wsts_pkg::PEND_FIELD_MAX);
      end else begin
        s2_pending <= wsts_pkg::PEND_FIELD_BITS'(pending_next);
      end
    end
  end

  assign task_res.valid         = s2_valid;
  assign task_res.granted       = s2_granted;
  assign task_res.task_out      = s2_granted ? wsts_pkg::TASK_FIELD_BITS'(store_rd) : '0;
  assign task_res.source_worker = s2_source;
  assign task_res.stolen        = s2_stolen;
  assign task_res.dropped       = s2_dropped;
  assign task_res.pending_total = s2_pending;

endmodule

// ===== rtl/core/wsts_checker.sv =====
module wsts_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    req_valid,
  input logic                                    req_ready,
  input logic                                    res_valid,
  input logic                                    res_ready,
  input logic                                    granted,
  input logic [wsts_pkg::TASK_FIELD_BITS-1:0]    task_out,
  input logic [wsts_pkg::WIDX_BITS-1:0]          source_worker,
  input logic                                    stolen,
  input logic                                    dropped,
  input logic [wsts_pkg::PEND_FIELD_BITS-1:0]    pending_total
);

  // a waiting result keeps its grant, task, source and pending total
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(granted) && $stable(task_out)
      && $stable(source_worker) && $stable(pending_total))
    else $error("result changed while stalled");

  // one item at a time through the update stage
  a_req_gap: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second transfer before update stage drained");

  // no grant means empty task fields
  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    res_valid && !granted |-> task_out == '0 && source_worker == '0 && !stolen)
    else $error("task fields set without a grant");

  // a refused submit never grants
  a_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid && dropped |-> !granted)
    else $error("dropped and granted together");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind work_stealing_task_scheduler wsts_checker u_wsts_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (task_req.valid),
  .req_ready     (task_req.ready),
  .res_valid     (task_res.valid),
  .res_ready     (task_res.ready),
  .granted       (task_res.granted),
  .task_out      (task_res.task_out),
  .source_worker (task_res.source_worker),
  .stolen        (task_res.stolen),
  .dropped       (task_res.dropped),
  .pending_total (task_res.pending_total)
);

// ===== test/testbench.sv =====
module testbench;

  localparam int WORKERS    = 8;
  localparam int DEPTH      = 16;
  localparam int SLOT_BITS  = $clog2(DEPTH);
  localparam int HOLD_LEN   = 80;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 40;

  // one item as offered on task_req
  typedef struct packed {
    logic                                 mode;
    logic [wsts_pkg::WIDX_BITS-1:0]       worker_index;
    logic [wsts_pkg::TASK_FIELD_BITS-1:0] task_in;
  } sched_item_t;

  // one result as seen on task_res
  typedef struct packed {
    logic                                 granted;
    logic [wsts_pkg::TASK_FIELD_BITS-1:0] task_out;
    logic [wsts_pkg::WIDX_BITS-1:0]       source_worker;
    logic                                 stolen;
    logic                                 dropped;
    logic [wsts_pkg::PEND_FIELD_BITS-1:0] pending_total;
  } sched_outcome_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wsts_req_if task_req_ch ();
  wsts_res_if task_res_ch ();
  wsts_cfg_if cfg_ch ();

  work_stealing_task_scheduler #(
    .NUM_WORKERS (WORKERS),
    .DEQUE_DEPTH (DEPTH),
    .TASK_BITS   (wsts_pkg::TASK_FIELD_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .task_req (task_req_ch),
    .task_res (task_res_ch),
    .cfg      (cfg_ch)
  );

  // shadow copy of the deques, the occupancy and the active count
  logic [wsts_pkg::TASK_FIELD_BITS-1:0] task_slots [WORKERS][DEPTH];
  logic [SLOT_BITS-1:0]                 front_slot [WORKERS];
  logic [SLOT_BITS:0]                   fill_level [WORKERS];
  int                                   held_tasks;
  logic [wsts_pkg::CFG_BITS-1:0]        active_setting;

  // items waiting for the driver, results waiting for the block
  sched_item_t    item_backlog [$];
  sched_outcome_t sched_outcomes [$];

  int unsigned queued_items   = 0;
  int unsigned accepted_items = 0;
  int unsigned outcome_seen   = 0;
  int          error_count    = 0;

  // handshake flags between the monitor and the negedge processes
  bit req_taken = 1'b0;
  bit cfg_taken = 1'b0;

  // idle rates in percent, and the long receiver hold request
  int send_idle_pct = 14;
  int recv_idle_pct = 83;
  int hold_asked    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  // a zero count acts as one, anything above the worker count as the worker count
  function automatic int live_count(logic [wsts_pkg::CFG_BITS-1:0] setting);
    if (setting == 0) return 1;
    if (setting > WORKERS) return WORKERS;
    return int'(setting);
  endfunction

  // apply one item to the shadow deques and give the result it must produce
  function automatic sched_outcome_t schedule_item(sched_item_t it);
    sched_outcome_t res;
    int n;
    int w;
    int j;
    int slot;
    bit found;
    res   = '0;
    n     = live_count(active_setting);
    w     = int'(it.worker_index);
    found = 1'b0;
    if (it.mode == wsts_pkg::MODE_SUBMIT) begin
      // refused on a full deque or an index past the active count
      if (w >= n || fill_level[w] >= DEPTH) begin
        res.dropped = 1'b1;
      end else begin
        slot = (int'(front_slot[w]) + int'(fill_level[w])) % DEPTH;
        task_slots[w][slot] = it.task_in;
        fill_level[w] = fill_level[w] + 1'b1;
        held_tasks++;
      end
    end else if (w < n) begin
      if (fill_level[w] != 0) begin
        // own deque: newest task from the back
        slot = (int'(front_slot[w]) + int'(fill_level[w]) - 1) % DEPTH;
        res.granted       = 1'b1;
        res.task_out      = task_slots[w][slot];
        res.source_worker = wsts_pkg::WIDX_BITS'(w);
        fill_level[w]     = fill_level[w] - 1'b1;
        held_tasks--;
      end else begin
        // steal the oldest task of the first non-empty deque after w, wrapping
        for (int k = 1; k < n; k++) begin
          j = (w + k) % n;
          if (!found && fill_level[j] != 0) begin
            slot              = int'(front_slot[j]);
            res.granted       = 1'b1;
            res.task_out      = task_slots[j][slot];
            res.source_worker = wsts_pkg::WIDX_BITS'(j);
            res.stolen        = 1'b1;
            front_slot[j]     = SLOT_BITS'((slot + 1) % DEPTH);
            fill_level[j]     = fill_level[j] - 1'b1;
            held_tasks--;
            found             = 1'b1;
          end
        end
      end
    end
    res.pending_total = wsts_pkg::PEND_FIELD_BITS'((held_tasks > wsts_pkg::PEND_FIELD_MAX) ?
                                                   wsts_pkg::PEND_FIELD_MAX : held_tasks);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("mismatch at result %0d: %s", outcome_seen, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // driver: holds an offered item until its transfer, then maybe idles
  always @(negedge clk) begin : drive_items
    sched_item_t nxt;
    if (rst) begin
      task_req_ch.valid <= 1'b0;
    end else if (!task_req_ch.valid || req_taken) begin
      if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = item_backlog[0];
        item_backlog.delete(0);
        task_req_ch.valid        <= 1'b1;
        task_req_ch.mode         <= nxt.mode;
        task_req_ch.worker_index <= nxt.worker_index;
        task_req_ch.task_in      <= nxt.task_in;
      end else begin
        task_req_ch.valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // receiver: random stalls, plus a long hold when asked for one
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      task_res_ch.ready <= 1'b0;
    end else begin
      task_res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: checks results in order, predicts on each input transfer
  always @(posedge clk) begin : observe
    sched_outcome_t got;
    sched_outcome_t want;
    sched_item_t    seen;
    if (!rst) begin
      if (task_res_ch.valid && task_res_ch.ready) begin
        got.granted       = task_res_ch.granted;
        got.task_out      = task_res_ch.task_out;
        got.source_worker = task_res_ch.source_worker;
        got.stolen        = task_res_ch.stolen;
        got.dropped       = task_res_ch.dropped;
        got.pending_total = task_res_ch.pending_total;
        if (sched_outcomes.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = sched_outcomes[0];
          sched_outcomes.delete(0);
          check_field("granted", 32'(got.granted), 32'(want.granted));
          check_field("task_out", 32'(got.task_out), 32'(want.task_out));
          check_field("source_worker", 32'(got.source_worker), 32'(want.source_worker));
          check_field("stolen", 32'(got.stolen), 32'(want.stolen));
          check_field("dropped", 32'(got.dropped), 32'(want.dropped));
          check_field("pending_total", 32'(got.pending_total), 32'(want.pending_total));
        end
        outcome_seen++;
      end
      if (task_req_ch.valid && task_req_ch.ready) begin
        seen.mode         = task_req_ch.mode;
        seen.worker_index = task_req_ch.worker_index;
        seen.task_in      = task_req_ch.task_in;
        sched_outcomes.insert(sched_outcomes.size(), schedule_item(seen));
        accepted_items++;
        req_taken = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        active_setting = cfg_ch.active_workers;
        cfg_taken      = 1'b1;
      end
    end
  end

  task automatic enqueue(logic m, int w, int t);
    sched_item_t it;
    it.mode         = m;
    it.worker_index = wsts_pkg::WIDX_BITS'(w);
    it.task_in      = wsts_pkg::TASK_FIELD_BITS'(t);
    item_backlog.insert(item_backlog.size(), it);
    queued_items++;
  endtask

  // sender pause: all items taken, all results back, then an idle wait
  task automatic settle();
    while (accepted_items != queued_items) @(negedge clk);
    while (sched_outcomes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_active(logic [wsts_pkg::CFG_BITS-1:0] v);
    @(negedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.active_workers <= v;
    do @(negedge clk); while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_ch.valid <= 1'b0;
  endtask

  // random traffic: mostly push bursts followed by requests, some deque fills,
  // request runs that force steals, and a little fully random noise
  task automatic gen_random(int n_items, logic [wsts_pkg::CFG_BITS-1:0] setting);
    int live;
    int made;
    int w;
    int k;
    int r;
    live = live_count(setting);
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        w = $urandom_range(0, live - 1);
        k = $urandom_range(1, 6);
        repeat (k) enqueue(wsts_pkg::MODE_SUBMIT,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, live - 1) : w,
                           $urandom_range(0, 65535));
        repeat (k) enqueue(wsts_pkg::MODE_REQUEST, $urandom_range(0, live - 1),
                           $urandom_range(0, 65535));
        made += 2 * k;
      end else if (r < 67) begin
        w = $urandom_range(0, live - 1);
        k = $urandom_range(15, 18);
        repeat (k) enqueue(wsts_pkg::MODE_SUBMIT, w, $urandom_range(0, 65535));
        made += k;
      end else if (r < 85) begin
        k = $urandom_range(2, 8);
        repeat (k) enqueue(wsts_pkg::MODE_REQUEST, $urandom_range(0, live - 1),
                           $urandom_range(0, 65535));
        made += k;
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) enqueue(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                           $urandom_range(0, 65535));
        made += k;
      end
    end
  endtask

  function automatic logic [wsts_pkg::CFG_BITS-1:0] phase_setting(int ph);
    case (ph)
      0:       return 4'd3;
      1:       return 4'd1;
      2:       return 4'd0;
      3:       return 4'd15;
      4:       return 4'd5;
      5:       return 4'd2;
      6:       return 4'd8;
      7:       return 4'd7;
      8:       return 4'd12;
      9:       return 4'd4;
      10:      return 4'd6;
      default: return 4'd8;
    endcase
  endfunction

  // stimulus
  initial begin
    int spin;
    task_req_ch.valid        = 1'b0;
    task_req_ch.mode         = wsts_pkg::MODE_SUBMIT;
    task_req_ch.worker_index = '0;
    task_req_ch.task_in      = '0;
    task_res_ch.ready        = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.active_workers    = wsts_pkg::ACTIVE_RESET;
    for (int i = 0; i < WORKERS; i++) begin
      front_slot[i] = '0;
      fill_level[i] = '0;
    end
    held_tasks     = 0;
    active_setting = wsts_pkg::ACTIVE_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: all eight workers active
    write_active(4'd8);
    enqueue(wsts_pkg::MODE_SUBMIT, 0, 16'hFFFF);
    enqueue(wsts_pkg::MODE_SUBMIT, 0, 16'h0000);
    enqueue(wsts_pkg::MODE_SUBMIT, 7, 16'hA5A5);
    enqueue(wsts_pkg::MODE_SUBMIT, 7, 16'h5A5A);
    enqueue(wsts_pkg::MODE_REQUEST, 0, 16'hFFFF);   // own pop, newest first
    enqueue(wsts_pkg::MODE_REQUEST, 0, 16'h0000);
    enqueue(wsts_pkg::MODE_REQUEST, 0, 16'h0000);   // empty, steals worker 7 front
    enqueue(wsts_pkg::MODE_REQUEST, 3, 16'hFFFF);   // steals the rest of worker 7
    enqueue(wsts_pkg::MODE_SUBMIT, 1, 16'h1234);
    enqueue(wsts_pkg::MODE_REQUEST, 6, 16'h0000);   // search wraps past 7 to worker 1
    enqueue(wsts_pkg::MODE_SUBMIT, 3, 16'h8001);    // stays held across the lowered count
    settle();

    // directed: two workers active
    write_active(4'd2);
    enqueue(wsts_pkg::MODE_SUBMIT, 5, 16'hBEEF);    // bad index, dropped
    enqueue(wsts_pkg::MODE_REQUEST, 6, 16'h0000);   // inactive requester, no grant
    enqueue(wsts_pkg::MODE_REQUEST, 0, 16'h0000);   // worker 3 out of reach, no grant
    // last one finds the deque full
    repeat (DEPTH + 1) enqueue(wsts_pkg::MODE_SUBMIT, 1, $urandom_range(0, 65535));
    settle();

    // random phases with changing active counts and idle patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 14;
        recv_idle_pct = 83;
      end else if (ph < 8) begin
        send_idle_pct = 83;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_active(phase_setting(ph));
      if (ph == 5) begin
        // sender stops mid-phase until everything is back
        gen_random(PHASE_LEN / 2, phase_setting(ph));
        settle();
        gen_random(PHASE_LEN / 2, phase_setting(ph));
      end else begin
        gen_random(PHASE_LEN, phase_setting(ph));
      end
      // long result-side hold while the sender keeps offering
      if (ph == 8) hold_asked++;
      settle();
    end

    // final drain, bounded
    while (accepted_items != queued_items) @(negedge clk);
    spin = 0;
    while (sched_outcomes.size() != 0 && spin < 5000) begin
      @(negedge clk);
      spin++;
    end
    repeat (10) @(negedge clk);
    if (sched_outcomes.size() != 0) report_mismatch("results never arrived");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wsts_pkg.sv
rtl/core/wsts_if.sv
rtl/core/work_stealing_task_scheduler.sv
rtl/core/wsts_checker.sv
test/testbench.sv
